// ----- src/rwhr_pkg.sv -----
// ----------------------------------------------------------------------------
// Randomized Walsh-Hadamard row package
// Shared constants, the sequencer state type and a small helper function.
// ----------------------------------------------------------------------------
package rwhr_pkg;

	localparam int MAX_LEN      = 64;
	localparam int BUF_SLOTS    = 64;
	localparam int ADDR_W       = 6;
	localparam int CNT_W        = 7;
	localparam int STAGE_W      = 3;
	localparam int IN_W         = 24;
	localparam int DATA_W       = 32;
	localparam int COEF_W       = 18;
	localparam int PROD_W       = DATA_W + COEF_W;
	localparam int SHIFT_BASE   = 16;

	localparam logic [COEF_W-1:0] INV_SQRT2_Q16 = 18'd46341;
	localparam logic [COEF_W-1:0] UNITY_Q16     = 18'd65536;

	typedef enum logic [3:0] {
		ST_COLLECT,
		ST_PAD,
		ST_BF_RD,
		ST_BF_WA,
		ST_BF_WB,
		ST_OUT_RD,
		ST_OUT_MUL,
		ST_OUT_SH,
		ST_OUT_WAIT
	} state_t;

	// Smallest k with 2^k >= n, for n from 1 to 64.
	function automatic logic [STAGE_W-1:0] ceil_log2(input logic [CNT_W-1:0] n);
		logic [STAGE_W-1:0] r;
		r = '0;
		for (int i = 0; i < ADDR_W; i++) begin
			if ((CNT_W'(1) << i) < n) begin
				r = STAGE_W'(i + 1);
			end
		end
		return r;
	endfunction

endpackage

// ----- src/randomized_walsh_hadamard_row_top.sv -----
// ----------------------------------------------------------------------------
// Randomized Walsh-Hadamard row transform
// Collects a row with random sign flips, zero-pads it to a power of two,
// runs the fast Walsh-Hadamard butterflies in place and emits scaled
// coefficients.
//
//   channel   fields                               handshake
//   sample    sample_value, negate, row_end        sample_valid / sample_stall
//   coef      coef_value, coef_last, overflowed    coef_valid / coef_stall
//
// Each element within MAX_LEN is written to the buffer as it is accepted.
// After the closing item the row is zero-padded, the butterflies run on
// the single butterfly unit and its buffer ports, and each coefficient is
// read, scaled, shifted and held until the coef channel takes it.
// The input is stalled from the closing item until the last coefficient
// is taken. The row buffer needs no clearing after reset.
// ----------------------------------------------------------------------------
module randomized_walsh_hadamard_row_top #(
	parameter int MAX_LEN = rwhr_pkg::MAX_LEN
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	output logic                              sample_stall,
	input  logic signed [rwhr_pkg::IN_W-1:0]  sample_value,
	input  logic                              negate,
	input  logic                              row_end,
	output logic                              coef_valid,
	input  logic                              coef_stall,
	output logic signed [rwhr_pkg::DATA_W-1:0] coef_value,
	output logic                              coef_last,
	output logic                              overflowed
);

	localparam int AW = rwhr_pkg::ADDR_W;
	localparam int CW = rwhr_pkg::CNT_W;
	localparam int SW = rwhr_pkg::STAGE_W;
	localparam int DW = rwhr_pkg::DATA_W;

	rwhr_pkg::state_t state_q, state_d;

	logic [CW-1:0]  count_q;
	logic           ovf_q;
	logic [CW-1:0]  idx_q;
	logic [SW-1:0]  stage_q;
	logic [DW-1:0]  diff_q;
	logic signed [rwhr_pkg::PROD_W-1:0] prod_q;
	logic           out_valid_q;
	logic [DW-1:0]  coef_value_q;
	logic           coef_last_q;
	logic           overflowed_q;

	logic           we;
	logic [AW-1:0]  waddr, raddr_a, raddr_b;
	logic [DW-1:0]  wdata, rdata_a, rdata_b;

	logic           in_acc, out_acc, store_ok;
	logic [SW-1:0]  k;
	logic [CW-1:0]  p, half;
	logic [AW-1:0]  t, lenv, bf_a, bf_b;
	logic           t_last, stage_last;
	logic [DW-1:0]  x_ext;
	logic [rwhr_pkg::COEF_W-1:0] mul_coef;
	logic [4:0]     shamt;

	assign in_acc   = sample_valid && !sample_stall;
	assign out_acc  = coef_valid && !coef_stall;
	assign store_ok = count_q < CW'(MAX_LEN);

	assign k    = rwhr_pkg::ceil_log2(count_q);
	assign p    = CW'(1) << k;
	assign half = p >> 1;

	assign t          = idx_q[AW-1:0];
	assign lenv       = AW'(1) << stage_q;
	assign bf_a       = (((t >> stage_q) << stage_q) << 1) | (t & (lenv - AW'(1)));
	assign bf_b       = bf_a | lenv;
	assign t_last     = idx_q == (half - CW'(1));
	assign stage_last = stage_q == (k - SW'(1));

	assign x_ext    = negate ? -DW'(sample_value) : DW'(sample_value);
	assign mul_coef = k[0] ? rwhr_pkg::INV_SQRT2_Q16 : rwhr_pkg::UNITY_Q16;
	assign shamt    = 5'(rwhr_pkg::SHIFT_BASE) + 5'(k >> 1);

	rwhr_ram #(
		.WIDTH(DW),
		.DEPTH(rwhr_pkg::BUF_SLOTS)
	) u_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			rwhr_pkg::ST_COLLECT: begin
				if (in_acc && row_end) begin
					state_d = rwhr_pkg::ST_PAD;
				end
			end
			rwhr_pkg::ST_PAD: begin
				if (idx_q >= p) begin
					state_d = (k == '0) ? rwhr_pkg::ST_OUT_RD : rwhr_pkg::ST_BF_RD;
				end
			end
			rwhr_pkg::ST_BF_RD: state_d = rwhr_pkg::ST_BF_WA;
			rwhr_pkg::ST_BF_WA: state_d = rwhr_pkg::ST_BF_WB;
			rwhr_pkg::ST_BF_WB: begin
				state_d = (t_last && stage_last) ? rwhr_pkg::ST_OUT_RD : rwhr_pkg::ST_BF_RD;
			end
			rwhr_pkg::ST_OUT_RD:  state_d = rwhr_pkg::ST_OUT_MUL;
			rwhr_pkg::ST_OUT_MUL: state_d = rwhr_pkg::ST_OUT_SH;
			rwhr_pkg::ST_OUT_SH:  state_d = rwhr_pkg::ST_OUT_WAIT;
			rwhr_pkg::ST_OUT_WAIT: begin
				if (!coef_stall) begin
					state_d = coef_last_q ? rwhr_pkg::ST_COLLECT : rwhr_pkg::ST_OUT_RD;
				end
			end
			default: state_d = rwhr_pkg::ST_COLLECT;
		endcase
	end

	always_comb begin
		sample_stall = 1'b1;
		we           = 1'b0;
		waddr        = '0;
		wdata        = '0;
		raddr_a      = '0;
		raddr_b      = '0;
		case (state_q)
			rwhr_pkg::ST_COLLECT: begin
				sample_stall = 1'b0;
				we           = sample_valid && store_ok;
				waddr        = count_q[AW-1:0];
				wdata        = x_ext;
			end
			rwhr_pkg::ST_PAD: begin
				we    = idx_q < p;
				waddr = idx_q[AW-1:0];
			end
			rwhr_pkg::ST_BF_RD: begin
				raddr_a = bf_a;
				raddr_b = bf_b;
			end
			rwhr_pkg::ST_BF_WA: begin
				we    = 1'b1;
				waddr = bf_a;
				wdata = rdata_a + rdata_b;
			end
			rwhr_pkg::ST_BF_WB: begin
				we    = 1'b1;
				waddr = bf_b;
				wdata = diff_q;
			end
			rwhr_pkg::ST_OUT_RD: begin
				raddr_a = idx_q[AW-1:0];
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rwhr_pkg::ST_COLLECT;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			idx_q       <= '0;
			stage_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				rwhr_pkg::ST_COLLECT: begin
					if (in_acc) begin
						if (store_ok) begin
							count_q <= count_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (row_end) begin
							idx_q <= count_q + CW'(store_ok);
						end
					end
				end
				rwhr_pkg::ST_PAD: begin
					if (idx_q < p) begin
						idx_q <= idx_q + CW'(1);
					end else begin
						idx_q   <= '0;
						stage_q <= '0;
					end
				end
				rwhr_pkg::ST_BF_WB: begin
					if (t_last) begin
						idx_q   <= '0;
						stage_q <= stage_q + SW'(1);
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				rwhr_pkg::ST_OUT_SH: begin
					out_valid_q <= 1'b1;
				end
				rwhr_pkg::ST_OUT_WAIT: begin
					if (!coef_stall) begin
						out_valid_q <= 1'b0;
						if (coef_last_q) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							idx_q   <= '0;
						end else begin
							idx_q <= idx_q + CW'(1);
						end
					end
				end
				default: begin
					out_valid_q <= out_valid_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rwhr_pkg::ST_BF_WA) begin
			diff_q <= rdata_a - rdata_b;
		end
		if (state_q == rwhr_pkg::ST_OUT_MUL) begin
			prod_q <= $signed(rdata_a) * $signed({1'b0, mul_coef});
		end
		if (state_q == rwhr_pkg::ST_OUT_SH) begin
			coef_value_q <= DW'(prod_q >>> shamt);
			coef_last_q  <= idx_q == (p - CW'(1));
			overflowed_q <= ovf_q;
		end
	end

	assign coef_valid = out_valid_q;
	assign coef_value = coef_value_q;
	assign coef_last  = coef_last_q;
	assign overflowed = overflowed_q;

endmodule

// ----- src/rwhr_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, with registered read data.
// ----------------------------------------------------------------------------
module rwhr_ram #(
	parameter int WIDTH = rwhr_pkg::DATA_W,
	parameter int DEPTH = rwhr_pkg::BUF_SLOTS
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ----- src/rwhr_checker.sv -----
// ----------------------------------------------------------------------------
// Randomized Walsh-Hadamard row port checker
// Watches the top-level ports for handshake and sequencing errors.
// ----------------------------------------------------------------------------
module rwhr_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               sample_valid,
	input logic                               sample_stall,
	input logic                               row_end,
	input logic                               coef_valid,
	input logic                               coef_stall,
	input logic signed [rwhr_pkg::DATA_W-1:0] coef_value,
	input logic                               coef_last,
	input logic                               overflowed
);

	a_coef_hold: assert property (@(posedge clk) disable iff (!arst_n)
		coef_valid && coef_stall |=> coef_valid && $stable(coef_value)
			&& $stable(coef_last) && $stable(overflowed))
		else $error("Stalled coefficient item changed.");

	a_no_input_while_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		coef_valid |-> sample_stall)
		else $error("Sample input open while coefficients are pending.");

	a_row_close_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall && row_end |=> sample_stall)
		else $error("Sample input still open after the row closed.");

	a_coef_gap: assert property (@(posedge clk) disable iff (!arst_n)
		coef_valid && !coef_stall |=> !coef_valid)
		else $error("Coefficient item followed without a gap.");

endmodule

bind randomized_walsh_hadamard_row_top rwhr_checker u_rwhr_checker (.*);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Randomized Walsh-Hadamard row transform testbench
// Drives rows of signed samples with random sign flips into the block and
// compares every emitted coefficient against a bit-accurate transform model.
// A short table of directed rows covers the sample extremes, single-element
// rows and padding. It is followed by random rows of mixed length, among them
// full and overflowing rows, under random idling on both channels and one
// long hold-off on the coefficient side.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int  HALF_PERIOD  = 6;
	localparam int  ROW_SLOTS    = 64;
	localparam int  ITEMS_TARGET = 360;
	localparam int  CYCLE_LIMIT  = 3_000_000;
	localparam int  HOLD_CYCLES  = 400;
	localparam int  HOLD_AFTER   = 20;
	localparam int  DRAIN_CYCLES = 40;
	localparam int  MAX_REPORTS  = 10;
	localparam longint RECIP_ROOT2 = 46341;

	localparam logic signed [23:0] SAMPLE_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] SAMPLE_MIN = -24'sh800000;

	typedef struct packed {
		logic signed [31:0] value;
		logic               last;
		logic               ovf;
	} coef_t;

	typedef struct packed {
		logic signed [23:0] value;
		logic               neg;
		logic               fin;
		logic               typed;
		logic signed [31:0] coef;
	} stim_row_t;

	// Rows with a typed coefficient are single-element rows: the sample comes
	// out unchanged (after its sign flip), as the last and only coefficient.
	localparam stim_row_t DIRECTED [24] = '{
		'{24'sd0,       1'b0, 1'b1, 1'b1, 32'sd0},
		'{SAMPLE_MAX,   1'b0, 1'b1, 1'b1, 32'sd8388607},
		'{SAMPLE_MIN,   1'b0, 1'b1, 1'b1, -32'sd8388608},
		'{SAMPLE_MIN,   1'b1, 1'b1, 1'b1, 32'sd8388608},
		'{SAMPLE_MAX,   1'b1, 1'b1, 1'b1, -32'sd8388607},
		'{-24'sd1,      1'b0, 1'b1, 1'b1, -32'sd1},
		'{24'sd100,     1'b0, 1'b0, 1'b0, 32'sd0},
		'{24'sd300,     1'b1, 1'b1, 1'b0, 32'sd0},
		'{SAMPLE_MAX,   1'b0, 1'b0, 1'b0, 32'sd0},
		'{SAMPLE_MAX,   1'b0, 1'b0, 1'b0, 32'sd0},
		'{SAMPLE_MIN,   1'b1, 1'b1, 1'b0, 32'sd0},
		'{SAMPLE_MIN,   1'b0, 1'b0, 1'b0, 32'sd0},
		'{SAMPLE_MIN,   1'b0, 1'b0, 1'b0, 32'sd0},
		'{SAMPLE_MAX,   1'b1, 1'b0, 1'b0, 32'sd0},
		'{-24'sd3,      1'b0, 1'b0, 1'b0, 32'sd0},
		'{24'sd65536,   1'b1, 1'b1, 1'b0, 32'sd0},
		'{24'sd1,       1'b0, 1'b0, 1'b0, 32'sd0},
		'{24'sd2,       1'b1, 1'b0, 1'b0, 32'sd0},
		'{24'sd3,       1'b0, 1'b0, 1'b0, 32'sd0},
		'{24'sd4,       1'b1, 1'b0, 1'b0, 32'sd0},
		'{24'sh555555,  1'b0, 1'b0, 1'b0, 32'sd0},
		'{24'shAAAAAA,  1'b1, 1'b0, 1'b0, 32'sd0},
		'{-24'sd65536,  1'b0, 1'b0, 1'b0, 32'sd0},
		'{24'sd7,       1'b1, 1'b1, 1'b0, 32'sd0}
	};

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               sample_valid = 1'b0;
	logic               sample_stall;
	logic signed [23:0] sample_value = '0;
	logic               negate       = 1'b0;
	logic               row_end      = 1'b0;
	logic               coef_valid;
	logic               coef_stall;
	logic signed [31:0] coef_value;
	logic               coef_last;
	logic               overflowed;

	logic rx_stall = 1'b0;
	logic hold_req = 1'b0;
	assign coef_stall = rx_stall | hold_req;

	coef_t coef_expected [$];

	logic signed [31:0] row_store [ROW_SLOTS];
	int                 row_count   = 0;
	bit                 row_dropped = 1'b0;

	int items_sent  = 0;
	int coefs_seen  = 0;
	int err_count   = 0;
	int cycles      = 0;
	int tx_mode     = 0;
	int rx_mode     = 0;
	int rx_wait     = 0;

	randomized_walsh_hadamard_row_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_value (sample_value),
		.negate       (negate),
		.row_end      (row_end),
		.coef_valid   (coef_valid),
		.coef_stall   (coef_stall),
		.coef_value   (coef_value),
		.coef_last    (coef_last),
		.overflowed   (overflowed)
	);

	initial begin
		forever #HALF_PERIOD clk = ~clk;
	end

	function automatic int pick_wait(input int mode);
		if (mode == 0) begin
			return 0;
		end else if (mode == 1) begin
			return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
		end
		return $urandom_range(0, 15);
	endfunction

	function automatic logic signed [23:0] pick_sample();
		case ($urandom_range(0, 9))
			0:       return SAMPLE_MAX;
			1:       return SAMPLE_MIN;
			2, 3:    return 24'($signed($urandom_range(0, 511)) - 256);
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic queue_coef(ref coef_t q [$], input coef_t c);
		q.insert(q.size(), c);
	endtask

	// Stores one sample; on the closing sample it pads, transforms and scales
	// the row and appends its coefficients to fresh.
	task automatic hadamard_accept(input logic signed [23:0] value, input logic neg,
			input logic fin, ref coef_t fresh [$]);
		longint x;
		longint u;
		longint y;
		longint work [ROW_SLOTS];
		int     p;
		int     k;
		int     span;
		x = value;
		if (neg) begin
			x = -x;
		end
		if (row_count < rwhr_pkg::MAX_LEN && row_count < ROW_SLOTS) begin
			row_store[row_count] = 32'(x);
			row_count++;
		end else begin
			row_dropped = 1'b1;
		end
		if (!fin) begin
			return;
		end
		p = 1;
		k = 0;
		while (p < row_count && p < ROW_SLOTS) begin
			p = p << 1;
			k++;
		end
		for (int i = 0; i < p; i++) begin
			work[i] = (i < row_count) ? longint'(row_store[i]) : 0;
		end
		for (span = 1; span < p; span = span << 1) begin
			for (int i = 0; i < p; i += 2 * span) begin
				for (int j = 0; j < span; j++) begin
					u = work[i + j];
					work[i + j]        = u + work[i + span + j];
					work[i + span + j] = u - work[i + span + j];
				end
			end
		end
		for (int i = 0; i < p; i++) begin
			if ((k % 2) == 0) begin
				y = work[i] >>> (k / 2);
			end else begin
				y = (work[i] * RECIP_ROOT2) >>> (16 + (k - 1) / 2);
			end
			queue_coef(fresh, '{value: 32'(y), last: (i == p - 1), ovf: row_dropped});
		end
		row_count   = 0;
		row_dropped = 1'b0;
	endtask

	task automatic send_sample(input logic signed [23:0] value, input logic neg,
			input logic fin, input logic typed, input logic signed [31:0] coef);
		coef_t fresh [$];
		int    gap;
		gap = pick_wait(tx_mode);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_value <= value;
		negate       <= neg;
		row_end      <= fin;
		sample_valid <= 1'b1;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		items_sent++;
		hadamard_accept(value, neg, fin, fresh);
		if (typed) begin
			queue_coef(coef_expected, '{value: coef, last: 1'b1, ovf: 1'b0});
		end else begin
			foreach (fresh[i]) queue_coef(coef_expected, fresh[i]);
		end
	endtask

	always @(posedge clk) begin
		coef_t want;
		int    w;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			w = rx_wait;
			if (arst_n && coef_valid && !coef_stall) begin
				coefs_seen++;
				if (coef_expected.size() == 0) begin
					err_count++;
					if (err_count <= MAX_REPORTS) begin
						$display("unexpected coefficient: value %0d last %0b ovf %0b",
							coef_value, coef_last, overflowed);
					end
				end else begin
					want = coef_expected.pop_front();
					if (coef_value !== want.value || coef_last !== want.last ||
							overflowed !== want.ovf) begin
						err_count++;
						if (err_count <= MAX_REPORTS) begin
							$display("coefficient %0d: expected %0d/%0b/%0b, got %0d/%0b/%0b",
								coefs_seen, want.value, want.last, want.ovf,
								coef_value, coef_last, overflowed);
						end
					end
				end
				if ((coefs_seen % 32) == 0) begin
					rx_mode = $urandom_range(0, 2);
				end
				w = pick_wait(rx_mode);
			end
			if (w > 0) begin
				rx_stall <= 1'b1;
				rx_wait = w - 1;
			end else begin
				rx_stall <= 1'b0;
				rx_wait = 0;
			end
		end
	end

	// One long hold-off on the coefficient side after HOLD_AFTER coefficients.
	initial begin
		wait (coefs_seen >= HOLD_AFTER);
		@(posedge clk);
		hold_req <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_req <= 1'b0;
	end

	initial begin
		int row_idx;
		int len;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			send_sample(DIRECTED[i].value, DIRECTED[i].neg, DIRECTED[i].fin,
				DIRECTED[i].typed, DIRECTED[i].coef);
		end

		row_idx = 0;
		while (items_sent < ITEMS_TARGET) begin
			if (row_idx == 2) begin
				len = rwhr_pkg::MAX_LEN + $urandom_range(1, 4);
			end else if (row_idx == 4) begin
				len = rwhr_pkg::MAX_LEN;
			end else begin
				case ($urandom_range(0, 9))
					0, 1:    len = $urandom_range(13, 64);
					2:       len = $urandom_range(65, 72);
					default: len = $urandom_range(1, 12);
				endcase
			end
			if ((row_idx % 3) == 0) begin
				tx_mode = $urandom_range(0, 2);
			end
			for (int j = 0; j < len; j++) begin
				send_sample(pick_sample(), 1'($urandom), (j == len - 1), 1'b0, 32'sd0);
			end
			row_idx++;
		end
		sample_valid <= 1'b0;

		while (coef_expected.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0 && coef_expected.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ----- randomized_walsh_hadamard_row_top.f -----
src/rwhr_pkg.sv
src/rwhr_ram.sv
src/randomized_walsh_hadamard_row_top.sv
src/rwhr_checker.sv
tb/sv/tb_top.sv
